/* rtl/sdcd_pkg.sv */
// ----------------------------------------------------------------------------
// sdcd_pkg: shared types and constants for the SD clock divider selector
// Divisor limits, register indexes, divider handshake structs, FSM states.
// ----------------------------------------------------------------------------
package sdcd_pkg;

  localparam int WORD_W            = 32;
  localparam int MAX_EVEN_DIVISOR  = 2046;
  localparam int MAX_POW2_DIVISOR  = 256;
  localparam int EVEN_MODE_VERSION = 2;

  // smallest even value at or above the even limit ends an exhausted search
  localparam int EVEN_CAP = MAX_EVEN_DIVISOR + (MAX_EVEN_DIVISOR % 2);
  localparam int POW2_LOG = $clog2(MAX_POW2_DIVISOR);
  localparam int EVEN_W   = $clog2(EVEN_CAP + 1);
  localparam int DIV_W    = (EVEN_W > POW2_LOG + 1) ? EVEN_W : POW2_LOG + 1;

  localparam int CODE_W   = 10;
  localparam int GAP_W    = 31;
  localparam int VER_W    = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_CLOCK   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SPEC_VERSION = CFG_IDX_W'(1);

  localparam logic [WORD_W-1:0] BASE_CLOCK_RESET   = 32'd250000000;
  localparam logic [VER_W-1:0]  SPEC_VERSION_RESET = 8'd2;

  // two card clocks in ns
  localparam logic [WORD_W-1:0] TWO_TICKS_NS = 32'd2000000000;
  localparam logic [GAP_W-1:0]  GAP_MAX      = 31'h7FFF_FFFF;

  // shared divider request and response
  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUOT,
    ST_ACH,
    ST_GAP,
    ST_DONE
  } state_t;

endpackage

/* rtl/sd_clock_divider_select.sv */
// ----------------------------------------------------------------------------
// sd_clock_divider_select: SD host clock divisor selection
// Picks the card clock divisor for a requested rate, reports the achieved
// clock and the write spacing over two card clocks.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  input   | in        | in_valid/in_stall  | target_hz
//  output  | out       | out_valid/out_stall| divider_code, achieved_hz,
//          |           |                    | write_gap_ns, gap_saturated
//  config  | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  One transaction at a time. The shared divider retires two quotient bits a
//  cycle. Up to three divides per item (threshold, achieved clock, gap); the
//  threshold divide is skipped when even mode takes divisor 1 directly, and
//  the gap divide when the achieved clock is zero. in_stall is high until the
//  result sits in the output register; a stalled result holds the block.
//  Sync reset.
//
// Divisor math: base/div <= target exactly when div > base/(target+1), so
// one divide gives q = base/(target+1) and the divisor is the smallest
// candidate above q, capped where the search would stop.
// ----------------------------------------------------------------------------
module sd_clock_divider_select (
  input  logic                          clk,
  input  logic                          rst,
  // request transactions
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sdcd_pkg::WORD_W-1:0]   target_hz,
  // result transactions
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sdcd_pkg::CODE_W-1:0]   divider_code,
  output logic [sdcd_pkg::WORD_W-1:0]   achieved_hz,
  output logic [sdcd_pkg::GAP_W-1:0]    write_gap_ns,
  output logic                          gap_saturated,
  // register writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sdcd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sdcd_pkg::WORD_W-1:0]   cfg_data
);
  import sdcd_pkg::*;

  // smallest power of two above q, capped at the power-of-two limit
  function automatic logic [DIV_W-1:0] pow2_divisor(input logic [WORD_W-1:0] q);
    logic [DIV_W-1:0] res;
    res = DIV_W'(2 ** POW2_LOG);
    for (int i = POW2_LOG - 1; i >= 0; i--) begin
      if ({1'b0, q} < ((WORD_W+1)'(1) << i)) begin
        res = DIV_W'(2 ** i);
      end
    end
    return res;
  endfunction

  // smallest even number above q, capped at the even limit
  function automatic logic [DIV_W-1:0] even_divisor(input logic [WORD_W-1:0] q);
    logic [WORD_W:0]  k;
    logic [DIV_W-1:0] res;
    k = {1'b0, q | WORD_W'(1)} + (WORD_W+1)'(1);
    if (k >= (WORD_W+1)'(MAX_EVEN_DIVISOR)) begin
      res = DIV_W'(EVEN_CAP);
    end else begin
      res = k[DIV_W-1:0];
    end
    return res;
  endfunction

  // configuration registers
  logic [WORD_W-1:0] base_clock_hz;
  logic [VER_W-1:0]  spec_version;

  // work registers
  state_t            state, state_next;
  logic [DIV_W-1:0]  divisor;
  logic [WORD_W-1:0] achieved;
  logic [GAP_W-1:0]  gap;
  logic              sat;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic              in_accept;
  logic              even_mode;
  logic              direct;      // even mode, base at or below request: divisor 1
  logic [DIV_W-1:0]  divisor_pick;
  logic              out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign even_mode = (spec_version >= VER_W'(EVEN_MODE_VERSION));
  assign direct    = even_mode && (base_clock_hz <= target_hz);
  assign out_free  = !out_valid || !out_stall;
  assign divisor_pick = even_mode ? even_divisor(div_rsp.quotient)
                                  : pow2_divisor(div_rsp.quotient);

  always_ff @(posedge clk) begin
    if (rst) begin
      base_clock_hz <= BASE_CLOCK_RESET;
      spec_version  <= SPEC_VERSION_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BASE_CLOCK:   base_clock_hz <= cfg_data;
        REG_SPEC_VERSION: spec_version  <= cfg_data[VER_W-1:0];
        default: ;
      endcase
    end
  end

  sdcd_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next = direct ? ST_ACH : ST_QUOT;
        end
      end
      ST_QUOT: begin
        if (div_rsp.done) begin
          state_next = ST_ACH;
        end
      end
      ST_ACH: begin
        if (div_rsp.done) begin
          state_next = (div_rsp.quotient == '0) ? ST_DONE : ST_GAP;
        end
      end
      ST_GAP: begin
        if (div_rsp.done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // divider requests
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = base_clock_hz;
    div_req.divisor  = (WORD_W+1)'(1);
    unique case (state)
      ST_IDLE: begin
        div_req.start   = in_accept;
        div_req.divisor = direct ? (WORD_W+1)'(1)
                                 : {1'b0, target_hz} + (WORD_W+1)'(1);
      end
      ST_QUOT: begin
        div_req.start   = div_rsp.done;
        div_req.divisor = (WORD_W+1)'(divisor_pick);
      end
      ST_ACH: begin
        div_req.start    = div_rsp.done && (div_rsp.quotient != '0);
        div_req.dividend = TWO_TICKS_NS;
        div_req.divisor  = {1'b0, div_rsp.quotient};
      end
      ST_GAP, ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_accept) begin
      divisor <= DIV_W'(1);
    end
    if (state == ST_QUOT && div_rsp.done) begin
      divisor <= divisor_pick;
    end
    if (state == ST_ACH && div_rsp.done) begin
      achieved <= div_rsp.quotient;
      gap      <= GAP_MAX;
      sat      <= (div_rsp.quotient == '0);
    end
    if (state == ST_GAP && div_rsp.done) begin
      // 2e9 / achieved is below 2^31, so no saturation here
      gap <= div_rsp.quotient[GAP_W-1:0] + GAP_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      divider_code  <= divisor[CODE_W:1];
      achieved_hz   <= achieved;
      write_gap_ns  <= gap;
      gap_saturated <= sat;
    end
  end

endmodule

/* rtl/sdcd_div.sv */
// ----------------------------------------------------------------------------
// sdcd_div: iterative unsigned divider
// Restoring divide, 32-bit dividend by 33-bit divisor, two quotient bits a
// cycle; done is registered with the last step and pulses with the quotient held.
// ----------------------------------------------------------------------------
module sdcd_div (
  input  logic             clk,
  input  logic             rst,
  input  sdcd_pkg::div_req_t req,
  output sdcd_pkg::div_rsp_t rsp
);
  import sdcd_pkg::*;

  localparam int STEPS  = 2;
  localparam int CYCLES = WORD_W / STEPS;
  localparam int CNT_W  = $clog2(CYCLES);

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [WORD_W-1:0] num;     // dividend bits shift out, quotient bits in
  logic [WORD_W:0]   rem;
  logic [WORD_W:0]   dvs;

  logic [WORD_W-1:0] num_next;
  logic [WORD_W:0]   rem_next;

  always_comb begin
    logic [WORD_W+1:0] trial;
    logic              ge;
    num_next = num;
    rem_next = rem;
    for (int s = 0; s < STEPS; s++) begin
      trial = {rem_next, num_next[WORD_W-1]};
      ge    = (trial >= {1'b0, dvs});
      if (ge) begin
        trial = trial - {1'b0, dvs};
      end
      rem_next = trial[WORD_W:0];
      num_next = {num_next[WORD_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      num <= num_next;
      rem <= rem_next;
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = num;

endmodule

/* dv/sdcd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdcd_checker: scoreboard for the SD clock divider selector
// Watches the config, request and result channels, predicts the divisor
// setting for each accepted request and compares results in order.
// ----------------------------------------------------------------------------
module sdcd_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [sdcd_pkg::WORD_W-1:0]    target_hz,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [sdcd_pkg::CODE_W-1:0]    divider_code,
  input  logic [sdcd_pkg::WORD_W-1:0]    achieved_hz,
  input  logic [sdcd_pkg::GAP_W-1:0]     write_gap_ns,
  input  logic                           gap_saturated,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [sdcd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sdcd_pkg::WORD_W-1:0]    cfg_data,
  output int unsigned                    fail_count,
  output int unsigned                    pending
);
  import sdcd_pkg::*;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [WORD_W-1:0] achieved;
    logic [GAP_W-1:0]  gap;
    logic              saturated;
  } clock_setting_t;

  logic [WORD_W-1:0] base_hz;
  logic [VER_W-1:0]  spec_ver;
  clock_setting_t    expected_settings[$];
  int unsigned       mismatches = 0;

  assign fail_count = mismatches;

  function automatic clock_setting_t predict_clock_setting(input logic [WORD_W-1:0] rate);
    clock_setting_t s;
    int unsigned    div;
    logic [63:0]    gap;
    if (spec_ver >= EVEN_MODE_VERSION) begin
      if (base_hz <= rate) begin
        div = 1;
      end else begin
        div = 2;
        while (div < MAX_EVEN_DIVISOR && base_hz / div > rate) div += 2;
      end
    end else begin
      div = 1;
      while (div < MAX_POW2_DIVISOR && base_hz / div > rate) div *= 2;
    end
    s.code     = CODE_W'(div >> 1);
    s.achieved = base_hz / div;
    if (s.achieved == 0) begin
      s.gap       = GAP_MAX;
      s.saturated = 1'b1;
    end else begin
      gap = 64'(TWO_TICKS_NS) / 64'(s.achieved) + 64'd1;
      s.gap       = (gap > 64'(GAP_MAX)) ? GAP_MAX : GAP_W'(gap);
      s.saturated = 1'b0;
    end
    return s;
  endfunction

  task automatic check_field(input string what, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    clock_setting_t want;
    if (rst) begin
      base_hz  = BASE_CLOCK_RESET;
      spec_ver = SPEC_VERSION_RESET;
      expected_settings.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_BASE_CLOCK) base_hz = cfg_data;
        else if (cfg_index == REG_SPEC_VERSION) spec_ver = cfg_data[VER_W-1:0];
      end
      if (in_valid && !in_stall) expected_settings.push_back(predict_clock_setting(target_hz));
      if (out_valid && !out_stall) begin
        if (expected_settings.size() == 0) begin
          mismatches++;
          $display("%0t: result with no request outstanding, code %0d achieved %0d",
                   $time, divider_code, achieved_hz);
        end else begin
          want = expected_settings.pop_front();
          check_field("divider_code", want.code, divider_code);
          check_field("achieved_hz", want.achieved, achieved_hz);
          check_field("write_gap_ns", want.gap, write_gap_ns);
          check_field("gap_saturated", want.saturated, gap_saturated);
        end
      end
    end
    pending = expected_settings.size();
  end

endmodule

/* dv/tb_sd_clock_divider_select.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sd_clock_divider_select: testbench for the SD clock divider selector
// Drives register writes and rate requests with random idle gaps and output
// stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_sd_clock_divider_select;
  import sdcd_pkg::*;

  // Register indexes with nothing behind them; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = CFG_IDX_W'(3);

  localparam int unsigned RANDOM_REQUESTS = 1400;
  // Longer than an item plus the longest stall and gap, with plenty to spare.
  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  localparam int unsigned TAIL_CYCLES     = 100;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [WORD_W-1:0]    target_hz;
  logic                 out_valid;
  logic                 out_stall;
  logic [CODE_W-1:0]    divider_code;
  logic [WORD_W-1:0]    achieved_hz;
  logic [GAP_W-1:0]     write_gap_ns;
  logic                 gap_saturated;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_data;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned quiet_cycles;

  // When set, neither side inserts gaps or stalls for the current phase.
  bit steady;
  // Base clock currently programmed, used to aim requests at divisor edges.
  logic [WORD_W-1:0] cur_base;

  sd_clock_divider_select i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .target_hz    (target_hz),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .divider_code (divider_code),
    .achieved_hz  (achieved_hz),
    .write_gap_ns (write_gap_ns),
    .gap_saturated(gap_saturated),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  sdcd_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .target_hz    (target_hz),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .divider_code (divider_code),
    .achieved_hz  (achieved_hz),
    .write_gap_ns (write_gap_ns),
    .gap_saturated(gap_saturated),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int unsigned idle_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Request rates: full range, tiny, the extremes, and rates right at the
  // truncated quotient of the base for both divisor families.
  function automatic logic [WORD_W-1:0] pick_rate();
    logic [WORD_W-1:0] q;
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2:    return $urandom_range(0, 1000);
      3: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return 32'd1;
          2:       return '1;
          default: return cur_base;
        endcase
      end
      4, 5, 6: begin
        q = cur_base / $urandom_range(1, MAX_EVEN_DIVISOR + 4);
        return q + $urandom_range(0, 2) - 1;
      end
      7, 8: begin
        q = cur_base >> $urandom_range(0, POW2_LOG + 1);
        return q + $urandom_range(0, 2) - 1;
      end
      default: return $urandom_range(100000, 208000000);
    endcase
  endfunction

  // Called at a falling edge; leaves cfg_valid high so back-to-back writes
  // never lower and raise it in the same step.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Program both registers in random order, sometimes poking an unmapped
  // index too. Upper data bits on the version write are junk on purpose.
  task automatic configure(input logic [WORD_W-1:0] base, input logic [VER_W-1:0] ver);
    logic [WORD_W-1:0] ver_word;
    ver_word = {$urandom} << VER_W | WORD_W'(ver);
    if ($urandom_range(0, 4) == 0)
      write_register($urandom_range(0, 1) ? REG_UNMAPPED_HI : REG_UNMAPPED_LO, $urandom);
    if ($urandom_range(0, 1)) begin
      write_register(REG_BASE_CLOCK, base);
      write_register(REG_SPEC_VERSION, ver_word);
    end else begin
      write_register(REG_SPEC_VERSION, ver_word);
      write_register(REG_BASE_CLOCK, base);
    end
    cfg_valid <= 1'b0;
    cur_base = base;
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance
  // with in_valid still high, so the next request can follow with no gap.
  task automatic send_request(input logic [WORD_W-1:0] rate);
    int unsigned gap;
    gap = idle_cycles();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    target_hz <= rate;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Block is idle once every expected result has been taken.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Result side: either take results at once, or hold stall high and keep
  // a presented result waiting for a while before letting it through.
  initial begin
    int unsigned hold;
    wait (!rst);
    @(negedge clk);
    forever begin
      hold = idle_cycles();
      if (hold != 0) begin
        out_stall <= 1'b1;
        do @(posedge clk); while (!out_valid);
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Watchdog: any accepted transaction on any channel resets the count.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                 (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned sent;
    int unsigned n;
    int unsigned phase;
    logic [WORD_W-1:0] base;
    logic [VER_W-1:0]  ver;

    rst       = 1'b1;
    in_valid  = 1'b0;
    target_hz = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_BASE_CLOCK;
    cfg_data  = '0;
    steady    = 1'b0;
    cur_base  = BASE_CLOCK_RESET;

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ---- directed ---------------------------------------------------------
    // Reset settings, even mode: zero request exhausts the search, a full-
    // scale request and the base itself take divisor 1, just under the base
    // forces divisor 2, and just under base/2046 runs past the limit.
    send_request('0);
    send_request(32'd1);
    send_request('1);
    send_request(BASE_CLOCK_RESET);
    send_request(BASE_CLOCK_RESET - 1);
    send_request(32'd25000000);
    send_request(32'd400000);
    send_request(32'd122000);
    drain();

    // Power-of-two mode at the top base clock: exact hit at base/256, one
    // below it exhausts the search at 256.
    configure('1, VER_W'(EVEN_MODE_VERSION - 1));
    send_request('0);
    send_request('1);
    send_request(32'd16777215);
    send_request(32'd16777214);
    send_request(32'd1);
    drain();

    // Zero base clock: achieved clock is zero and the gap saturates.
    write_register(REG_UNMAPPED_HI, $urandom);
    configure('0, '1);
    send_request('0);
    send_request(32'd5);
    drain();

    // Small base in power-of-two mode: quotient of 3 at the cap.
    configure(32'd1000, '0);
    send_request(32'd1);
    send_request(32'd3);
    send_request('0);
    drain();

    // Base below the even limit: a zero request divides down to zero short of the cap.
    configure(32'd1500, VER_W'(EVEN_MODE_VERSION));
    send_request('0);
    send_request(32'd1);
    drain();

    // ---- random phases ----------------------------------------------------
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_REQUESTS) begin
      case (phase)
        0: begin base = '1;    ver = '1; end
        1: begin base = 32'd1; ver = '0; end
        default: begin
          case ($urandom_range(0, 5))
            0:       base = $urandom;
            1:       base = $urandom_range(0, 3000);
            2:       base = ($urandom_range(0, 1) != 0) ? '1 : '0;
            default: base = $urandom_range(1000000, 400000000);
          endcase
          case ($urandom_range(0, 4))
            0:       ver = VER_W'($urandom_range(0, 255));
            1:       ver = VER_W'(EVEN_MODE_VERSION - 1);
            2:       ver = VER_W'(EVEN_MODE_VERSION);
            3:       ver = '0;
            default: ver = VER_W'($urandom_range(EVEN_MODE_VERSION + 1, 10));
          endcase
        end
      endcase
      steady = ($urandom_range(0, 3) == 0);
      configure(base, ver);
      n = $urandom_range(60, 140);
      if (n > RANDOM_REQUESTS - sent) n = RANDOM_REQUESTS - sent;
      repeat (n) send_request(pick_rate());
      sent += n;
      drain();
      phase++;
    end

    // Let any stray result show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
